/* rtl/ges_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ges_pkg
// Shared types, constants and fixed-point helpers for the linear system solver.
// ----------------------------------------------------------------------------
package ges_pkg;

  localparam int unsigned DefMaxUnknowns = 3;
  localparam int unsigned EntryW         = 16;
  localparam int unsigned ValW           = 64;
  localparam int unsigned FracW          = 32;
  localparam int unsigned SizeW          = 2;
  localparam int unsigned IdxOutW        = 2;
  localparam logic [SizeW-1:0] SizeReset = 2'd3;

  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PIV_RD,
    ST_PIV_CHK,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_ELIM_J,
    ST_ELIM_RDN,
    ST_ELIM_RDD,
    ST_ELIM_DST,
    ST_ELIM_DIV,
    ST_ELIM_RDI,
    ST_ELIM_RDJ,
    ST_ELIM_MUL,
    ST_BACK_RDS,
    ST_BACK_SUM,
    ST_BACK_RDJ,
    ST_BACK_MST,
    ST_BACK_MUL,
    ST_BACK_RDP,
    ST_BACK_DST,
    ST_BACK_DIV,
    ST_BACK_EMIT,
    ST_SING_EMIT,
    ST_CLEAR
  } ges_state_e;

  // magnitude of a signed word; the most negative value maps to 2^63
  function automatic logic [ValW-1:0] mag_of(input logic signed [ValW-1:0] v);
    logic [ValW-1:0] r;
    r = v[ValW-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  // rebuild a signed word from sign and magnitude, saturating
  function automatic logic signed [ValW-1:0] from_mag(input logic neg, input logic over,
                                                      input logic [ValW-1:0] m);
    logic signed [ValW-1:0] r;
    if (neg) begin
      r = (over || m[ValW-1]) ? ValMin : -$signed(m);
    end else begin
      r = (over || m[ValW-1]) ? ValMax : $signed(m);
    end
    return r;
  endfunction

  function automatic logic signed [ValW-1:0] sat_sub(input logic signed [ValW-1:0] a,
                                                     input logic signed [ValW-1:0] b);
    logic signed [ValW:0] d;
    logic signed [ValW-1:0] r;
    d = {a[ValW-1], a} - {b[ValW-1], b};
    if (d[ValW] != d[ValW-1]) begin
      r = d[ValW] ? ValMin : ValMax;
    end else begin
      r = d[ValW-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/ges_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ges_div
// Radix-2 restoring divider for Q31.32 quotients (a << 32) / b, saturating.
// ----------------------------------------------------------------------------
module ges_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ges_pkg::ValW-1:0]   a_i,
  input  logic signed [ges_pkg::ValW-1:0]   b_i,
  output logic                              done_o,
  output logic signed [ges_pkg::ValW-1:0]   res_o
);

  localparam int unsigned NumW  = ges_pkg::ValW + ges_pkg::FracW;
  localparam int unsigned CntW  = $clog2(NumW + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CntW-1:0]             cnt_q;
  logic [NumW-1:0]             num_q;
  logic [ges_pkg::ValW-1:0]    rem_q;
  logic [ges_pkg::ValW-1:0]    den_q;
  logic [ges_pkg::ValW-1:0]    quo_q;
  logic                        over_q;
  logic                        neg_q;

  logic [ges_pkg::ValW:0]      trial;
  logic                        fits;
  logic [ges_pkg::ValW:0]      diff;
  logic [ges_pkg::ValW-1:0]    ua;
  logic [ges_pkg::ValW-1:0]    ub;

  assign ua    = ges_pkg::mag_of(a_i);
  assign ub    = ges_pkg::mag_of(b_i);
  assign trial = {rem_q, num_q[NumW-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // a zero divisor finishes at once with a saturated result
        busy_q <= (ub != '0);
        done_q <= (ub == '0);
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= {ua, {ges_pkg::FracW{1'b0}}};
      rem_q  <= '0;
      den_q  <= ub;
      quo_q  <= '0;
      over_q <= (ub == '0);
      neg_q  <= a_i[ges_pkg::ValW-1] ^ b_i[ges_pkg::ValW-1];
    end else if (busy_q) begin
      num_q  <= {num_q[NumW-2:0], 1'b0};
      rem_q  <= fits ? diff[ges_pkg::ValW-1:0] : trial[ges_pkg::ValW-1:0];
      over_q <= over_q | quo_q[ges_pkg::ValW-1];
      quo_q  <= {quo_q[ges_pkg::ValW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign res_o  = ges_pkg::from_mag(neg_q, over_q, quo_q);

endmodule

/* rtl/ges_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ges_mul
// Q31.32 multiplier built from four 32x32 partial products, saturating.
// ----------------------------------------------------------------------------
module ges_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ges_pkg::ValW-1:0]   a_i,
  input  logic signed [ges_pkg::ValW-1:0]   b_i,
  output logic                              done_o,
  output logic signed [ges_pkg::ValW-1:0]   res_o
);

  localparam int unsigned HalfW = ges_pkg::ValW / 2;
  localparam int unsigned AccW  = 2 * ges_pkg::ValW;

  logic                        busy_q;
  logic                        done_q;
  logic [2:0]                  ph_q;
  logic [ges_pkg::ValW-1:0]    ua_q;
  logic [ges_pkg::ValW-1:0]    ub_q;
  logic                        neg_q;
  logic [ges_pkg::ValW-1:0]    pp_q;
  logic [AccW-1:0]             acc_q;

  logic [HalfW-1:0]            opa;
  logic [HalfW-1:0]            opb;
  logic [AccW-1:0]             pp_shift;

  always_comb begin
    opa      = ua_q[HalfW-1:0];
    opb      = ub_q[HalfW-1:0];
    pp_shift = AccW'(pp_q);
    case (ph_q)
      3'd0: begin
        opa = ua_q[HalfW-1:0];
        opb = ub_q[HalfW-1:0];
      end
      3'd1: begin
        opa = ua_q[HalfW-1:0];
        opb = ub_q[ges_pkg::ValW-1:HalfW];
      end
      3'd2: begin
        opa = ua_q[ges_pkg::ValW-1:HalfW];
        opb = ub_q[HalfW-1:0];
      end
      3'd3: begin
        opa = ua_q[ges_pkg::ValW-1:HalfW];
        opb = ub_q[ges_pkg::ValW-1:HalfW];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    // product registered last cycle belongs to the previous phase
    case (ph_q)
      3'd2, 3'd3: pp_shift = AccW'(pp_q) << HalfW;
      3'd4:       pp_shift = AccW'(pp_q) << ges_pkg::ValW;
      default:    pp_shift = AccW'(pp_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
      end else if (busy_q) begin
        ph_q <= ph_q + 1'b1;
        if (ph_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= ges_pkg::mag_of(a_i);
      ub_q  <= ges_pkg::mag_of(b_i);
      neg_q <= a_i[ges_pkg::ValW-1] ^ b_i[ges_pkg::ValW-1];
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q <= opa * opb;
      if (ph_q != 3'd0) begin
        acc_q <= acc_q + pp_shift;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = ges_pkg::from_mag(neg_q, acc_q[AccW-1:ges_pkg::ValW+HalfW] != '0,
                                    acc_q[ges_pkg::ValW+HalfW-1:HalfW]);

endmodule

/* rtl/gaussian_elimination_solver_unit.sv */
`timescale 1ns / 1ps
// Loading takes one entry item per cycle while idle. The solve after the last entry runs on one
// shared 96-step divider and one multiplier, followed by a clear sweep over all
// MAX_UNKNOWNS*(MAX_UNKNOWNS+1) matrix cells. Input is not ready during solve and sweep.
// Reset clears control state and sets the size register to 3; the matrix memory holds no
// defined value until loaded.
// ----------------------------------------------------------------------------
// gaussian_elimination_solver_unit
// Linear system solver: forward elimination with pivot swap, back substitution.
// ----------------------------------------------------------------------------
module gaussian_elimination_solver_unit #(
  parameter int unsigned MAX_UNKNOWNS = ges_pkg::DefMaxUnknowns
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [ges_pkg::EntryW-1:0]     entry_value_i,
  input  logic                                  last_entry_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [ges_pkg::ValW-1:0]       solution_value_o,
  output logic [ges_pkg::IdxOutW-1:0]           unknown_index_o,
  output logic                                  singular_o,
  output logic                                  last_result_o,
  input  logic                                  cfg_we_i,
  input  logic [ges_pkg::SizeW-1:0]             cfg_wdata_i
);

  localparam int unsigned Cells = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
  localparam int unsigned AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned CW    = $clog2(Cells + 1);
  localparam int unsigned IW    = $clog2(MAX_UNKNOWNS + 2);
  localparam int unsigned RW    = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;

  ges_pkg::ges_state_e state_q, state_d;

  logic [ges_pkg::SizeW-1:0]           size_q;
  logic [CW-1:0]                       ld_cnt_q;
  logic [IW-1:0]                       i_q, j_q, k_q;
  logic [RW-1:0]                       perm_q [MAX_UNKNOWNS];
  logic signed [ges_pkg::ValW-1:0]     ratio_q, sum_q, rd_q;
  logic signed [ges_pkg::ValW-1:0]     sol_q [MAX_UNKNOWNS];
  logic signed [ges_pkg::ValW-1:0]     mem_q [Cells];

  logic                                out_valid_q;
  logic signed [ges_pkg::ValW-1:0]     out_val_q;
  logic [ges_pkg::IdxOutW-1:0]         out_idx_q;
  logic                                out_sing_q;
  logic                                out_last_q;

  logic [IW-1:0]   n, w;
  logic [CW-1:0]   load_lim;
  logic            in_acc, ld_ok, out_free;

  logic            rd_en, wr_en, lin_addr;
  logic [RW-1:0]   row_sel;
  logic [IW-1:0]   col_sel;
  logic [CW-1:0]   cell_addr;
  logic [AW-1:0]   addr;
  logic signed [ges_pkg::ValW-1:0] wr_data;

  logic                            div_start, div_done, mul_start, mul_done;
  logic signed [ges_pkg::ValW-1:0] mul_a, mul_b, div_res, mul_res;

  // effective size: zero counts as one, clip to the array size
  always_comb begin
    if (size_q == '0) begin
      n = IW'(1);
    end else if (int'(size_q) > int'(MAX_UNKNOWNS)) begin
      n = IW'(MAX_UNKNOWNS);
    end else begin
      n = IW'(size_q);
    end
  end

  assign w        = n + 1'b1;
  assign load_lim = CW'(n) * CW'(w);
  assign in_ready_o = (state_q == ges_pkg::ST_IDLE);
  assign in_acc   = in_valid_i && in_ready_o;
  assign ld_ok    = ld_cnt_q < load_lim;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ges_pkg::ST_IDLE:      if (in_acc && last_entry_i) state_d = ges_pkg::ST_PIV_RD;
      ges_pkg::ST_PIV_RD:    state_d = ges_pkg::ST_PIV_CHK;
      ges_pkg::ST_PIV_CHK:   state_d = (rd_q != '0) ? ges_pkg::ST_ELIM_J : ges_pkg::ST_SRCH_RD;
      ges_pkg::ST_SRCH_RD:   state_d = (j_q >= n) ? ges_pkg::ST_SING_EMIT
                                                  : ges_pkg::ST_SRCH_CHK;
      ges_pkg::ST_SRCH_CHK:  state_d = (rd_q != '0) ? ges_pkg::ST_ELIM_J : ges_pkg::ST_SRCH_RD;
      ges_pkg::ST_ELIM_J: begin
        if (j_q < n) begin
          state_d = ges_pkg::ST_ELIM_RDN;
        end else if (IW'(i_q + 1'b1) >= n) begin
          state_d = ges_pkg::ST_BACK_RDS;
        end else begin
          state_d = ges_pkg::ST_PIV_RD;
        end
      end
      ges_pkg::ST_ELIM_RDN:  state_d = ges_pkg::ST_ELIM_RDD;
      ges_pkg::ST_ELIM_RDD:  state_d = ges_pkg::ST_ELIM_DST;
      ges_pkg::ST_ELIM_DST:  state_d = ges_pkg::ST_ELIM_DIV;
      ges_pkg::ST_ELIM_DIV:  if (div_done) state_d = ges_pkg::ST_ELIM_RDI;
      ges_pkg::ST_ELIM_RDI:  state_d = ges_pkg::ST_ELIM_RDJ;
      ges_pkg::ST_ELIM_RDJ:  state_d = ges_pkg::ST_ELIM_MUL;
      ges_pkg::ST_ELIM_MUL: begin
        if (mul_done) state_d = (k_q == n) ? ges_pkg::ST_ELIM_J : ges_pkg::ST_ELIM_RDI;
      end
      ges_pkg::ST_BACK_RDS:  state_d = ges_pkg::ST_BACK_SUM;
      ges_pkg::ST_BACK_SUM:  state_d = ges_pkg::ST_BACK_RDJ;
      ges_pkg::ST_BACK_RDJ:  state_d = (j_q < n) ? ges_pkg::ST_BACK_MST : ges_pkg::ST_BACK_RDP;
      ges_pkg::ST_BACK_MST:  state_d = ges_pkg::ST_BACK_MUL;
      ges_pkg::ST_BACK_MUL:  if (mul_done) state_d = ges_pkg::ST_BACK_RDJ;
      ges_pkg::ST_BACK_RDP:  state_d = ges_pkg::ST_BACK_DST;
      ges_pkg::ST_BACK_DST:  state_d = ges_pkg::ST_BACK_DIV;
      ges_pkg::ST_BACK_DIV:  if (div_done) state_d = ges_pkg::ST_BACK_EMIT;
      ges_pkg::ST_BACK_EMIT: begin
        if (out_free) state_d = (i_q == '0) ? ges_pkg::ST_CLEAR : ges_pkg::ST_BACK_RDS;
      end
      ges_pkg::ST_SING_EMIT: if (out_free) state_d = ges_pkg::ST_CLEAR;
      ges_pkg::ST_CLEAR:     if (ld_cnt_q == CW'(Cells - 1)) state_d = ges_pkg::ST_IDLE;
      default:               state_d = ges_pkg::ST_IDLE;
    endcase
  end

  // memory and unit control
  always_comb begin
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    lin_addr  = 1'b0;
    row_sel   = perm_q[i_q[RW-1:0]];
    col_sel   = i_q;
    wr_data   = '0;
    div_start = 1'b0;
    mul_start = 1'b0;
    mul_a     = ratio_q;
    mul_b     = rd_q;
    case (state_q)
      ges_pkg::ST_IDLE: begin
        wr_en    = in_acc && ld_ok;
        lin_addr = 1'b1;
        wr_data  = {{(ges_pkg::ValW - ges_pkg::FracW - ges_pkg::EntryW){entry_value_i[
                   ges_pkg::EntryW-1]}}, entry_value_i, {ges_pkg::FracW{1'b0}}};
      end
      ges_pkg::ST_PIV_RD:   rd_en = 1'b1;
      ges_pkg::ST_SRCH_RD: begin
        rd_en   = (j_q < n);
        row_sel = perm_q[j_q[RW-1:0]];
      end
      ges_pkg::ST_ELIM_RDN: begin
        rd_en   = 1'b1;
        row_sel = perm_q[j_q[RW-1:0]];
      end
      ges_pkg::ST_ELIM_RDD: rd_en = 1'b1;
      ges_pkg::ST_ELIM_DST: div_start = 1'b1;
      ges_pkg::ST_ELIM_RDI: begin
        rd_en   = 1'b1;
        col_sel = k_q;
      end
      ges_pkg::ST_ELIM_RDJ: begin
        mul_start = 1'b1;
        rd_en     = 1'b1;
        row_sel   = perm_q[j_q[RW-1:0]];
        col_sel   = k_q;
      end
      ges_pkg::ST_ELIM_MUL: begin
        wr_en   = mul_done;
        row_sel = perm_q[j_q[RW-1:0]];
        col_sel = k_q;
        wr_data = ges_pkg::sat_sub(rd_q, mul_res);
      end
      ges_pkg::ST_BACK_RDS: begin
        rd_en   = 1'b1;
        col_sel = n;
      end
      ges_pkg::ST_BACK_RDJ: begin
        rd_en   = (j_q < n);
        col_sel = j_q;
      end
      ges_pkg::ST_BACK_MST: begin
        mul_start = 1'b1;
        mul_a     = rd_q;
        mul_b     = sol_q[j_q[RW-1:0]];
      end
      ges_pkg::ST_BACK_RDP: rd_en = 1'b1;
      ges_pkg::ST_BACK_DST: div_start = 1'b1;
      ges_pkg::ST_CLEAR: begin
        wr_en    = 1'b1;
        lin_addr = 1'b1;
      end
      default: ;
    endcase
  end

  assign cell_addr = lin_addr ? ld_cnt_q : CW'(CW'(row_sel) * CW'(w) + CW'(col_sel));
  assign addr      = cell_addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[addr];
  end

  ges_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (sum_q),
    .b_i     (rd_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  ges_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // sequencer counters and row order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ges_pkg::ST_IDLE;
      size_q   <= ges_pkg::SizeReset;
      ld_cnt_q <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      for (int r = 0; r < MAX_UNKNOWNS; r++) perm_q[r] <= RW'(r);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      case (state_q)
        ges_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (last_entry_i) begin
              ld_cnt_q <= '0;
              i_q      <= '0;
              for (int r = 0; r < MAX_UNKNOWNS; r++) perm_q[r] <= RW'(r);
            end else if (ld_ok) begin
              ld_cnt_q <= ld_cnt_q + 1'b1;
            end
          end
        end
        ges_pkg::ST_PIV_CHK: j_q <= IW'(i_q + 1'b1);
        ges_pkg::ST_SRCH_CHK: begin
          if (rd_q != '0) begin
            // swap row order instead of moving entries
            perm_q[i_q[RW-1:0]] <= perm_q[j_q[RW-1:0]];
            perm_q[j_q[RW-1:0]] <= perm_q[i_q[RW-1:0]];
            j_q <= IW'(i_q + 1'b1);
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ges_pkg::ST_ELIM_J: begin
          if (j_q >= n) i_q <= (IW'(i_q + 1'b1) >= n) ? IW'(n - 1'b1) : IW'(i_q + 1'b1);
        end
        ges_pkg::ST_ELIM_DIV: k_q <= i_q;
        ges_pkg::ST_ELIM_MUL: begin
          if (mul_done) begin
            if (k_q == n) j_q <= j_q + 1'b1;
            else k_q <= k_q + 1'b1;
          end
        end
        ges_pkg::ST_BACK_SUM: j_q <= IW'(i_q + 1'b1);
        ges_pkg::ST_BACK_MUL: if (mul_done) j_q <= j_q + 1'b1;
        ges_pkg::ST_BACK_EMIT: if (out_free && i_q != '0) i_q <= i_q - 1'b1;
        ges_pkg::ST_CLEAR: begin
          ld_cnt_q <= (ld_cnt_q == CW'(Cells - 1)) ? '0 : ld_cnt_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ges_pkg::ST_ELIM_RDD || state_q == ges_pkg::ST_BACK_SUM) sum_q <= rd_q;
    if (state_q == ges_pkg::ST_BACK_MUL && mul_done) sum_q <= ges_pkg::sat_sub(sum_q, mul_res);
    if (state_q == ges_pkg::ST_ELIM_DIV && div_done) ratio_q <= div_res;
    if (state_q == ges_pkg::ST_BACK_DIV && div_done) sol_q[i_q[RW-1:0]] <= div_res;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= (state_q == ges_pkg::ST_BACK_EMIT) || (state_q == ges_pkg::ST_SING_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && state_q == ges_pkg::ST_BACK_EMIT) begin
      out_val_q  <= sol_q[i_q[RW-1:0]];
      out_idx_q  <= i_q[ges_pkg::IdxOutW-1:0];
      out_sing_q <= 1'b0;
      out_last_q <= (i_q == '0);
    end else if (out_free && state_q == ges_pkg::ST_SING_EMIT) begin
      out_val_q  <= '0;
      out_idx_q  <= '0;
      out_sing_q <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign solution_value_o = out_val_q;
  assign unknown_index_o  = out_idx_q;
  assign singular_o       = out_sing_q;
  assign last_result_o    = out_last_q;

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_start && mul_start))
    else $error("divider and multiplier started together");

  a_last_starts_solve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_entry_i |=> !in_ready_o)
    else $error("input still ready after final entry");

  a_singular_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> last_result_o && solution_value_o == '0)
    else $error("singular result malformed");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ges_pkg::ST_IDLE && state_q != ges_pkg::ST_CLEAR |-> i_q < n)
    else $error("pivot row out of range");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the linear system solver. Loads augmented matrices entry by
// entry, predicts the Q31.32 solutions (or the singular flag) in the bench,
// and checks every result against the oldest prediction, with random gaps on
// the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DefMaxUnknowns = ges_pkg::DefMaxUnknowns;
  localparam int unsigned EntryW         = ges_pkg::EntryW;
  localparam int unsigned ValW           = ges_pkg::ValW;
  localparam int unsigned FracW          = ges_pkg::FracW;
  localparam int unsigned SizeW          = ges_pkg::SizeW;
  localparam int unsigned IdxOutW        = ges_pkg::IdxOutW;
  localparam int unsigned SizeReset      = ges_pkg::SizeReset;
  localparam logic signed [ValW-1:0] ValMax = ges_pkg::ValMax;
  localparam logic signed [ValW-1:0] ValMin = ges_pkg::ValMin;

  localparam int unsigned Cells     = DefMaxUnknowns * (DefMaxUnknowns + 1);
  localparam int unsigned IdleLimit = 20000;

  typedef logic signed [ValW-1:0] fx_t;

  typedef struct {
    fx_t             value;
    logic [IdxOutW-1:0] index;
    logic            sing;
    logic            last;
  } solution_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [EntryW-1:0] entry_value_i = '0;
  logic last_entry_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  fx_t solution_value_o;
  logic [IdxOutW-1:0] unknown_index_o;
  logic singular_o;
  logic last_result_o;
  logic cfg_we_i = 1'b0;
  logic [SizeW-1:0] cfg_wdata_i = '0;

  gaussian_elimination_solver_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .entry_value_i, .last_entry_i,
    .out_valid_o, .out_ready_i, .solution_value_o, .unknown_index_o,
    .singular_o, .last_result_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // bench copy of the solver state
  fx_t matrix_q[Cells];
  fx_t unknowns_q[DefMaxUnknowns];
  int unsigned loaded_cnt;
  int unsigned size_reg;
  solution_t pending_q[$];

  int unsigned error_cnt, items_sent, results_seen, systems_sent, singular_seen;
  int unsigned idle_cycles;
  int unsigned stall_hold;
  int unsigned burst_left;

  function automatic fx_t fx_pack(input logic neg, input logic over, input logic [63:0] m);
    if (neg) return (over || m > 64'h8000_0000_0000_0000) ? ValMin : fx_t'(-m);
    return (over || m[63]) ? ValMax : fx_t'(m);
  endfunction

  function automatic logic [63:0] fx_abs(input fx_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic signed [64:0] d;
    d = 65'(a) - 65'(b);
    if (d > 65'(ValMax)) return ValMax;
    if (d < 65'(ValMin)) return ValMin;
    return d[63:0];
  endfunction

  function automatic fx_t fx_mul(input fx_t a, input fx_t b);
    logic [127:0] p;
    p = {64'd0, fx_abs(a)} * {64'd0, fx_abs(b)};
    return fx_pack(a[63] ^ b[63], p[127:96] != 0, p[95:32]);
  endfunction

  function automatic fx_t fx_div(input fx_t a, input fx_t b);
    logic [127:0] q;
    if (b == 0) return fx_pack(a[63] ^ b[63], 1'b1, '0);
    q = {32'd0, fx_abs(a), 32'd0} / {64'd0, fx_abs(b)};
    return fx_pack(a[63] ^ b[63], q[127:64] != 0, q[63:0]);
  endfunction

  // load one entry; on the last entry solve and queue the expected results
  task automatic load_and_solve(input logic signed [EntryW-1:0] v, input logic lst);
    fx_t m[DefMaxUnknowns][DefMaxUnknowns+1];
    fx_t t, ratio, acc;
    int n, w, i, j, k, hit;
    logic ok;
    n = (size_reg == 0) ? 1 : (size_reg > DefMaxUnknowns ? DefMaxUnknowns : size_reg);
    w = n + 1;
    ok = 1'b1;
    if (loaded_cnt < n * w) begin
      matrix_q[loaded_cnt] = {{(ValW-EntryW-FracW){v[EntryW-1]}}, v, {FracW{1'b0}}};
      loaded_cnt++;
    end
    if (!lst) return;
    for (i = 0; i < n; i++)
      for (j = 0; j < w; j++) m[i][j] = matrix_q[i*w+j];
    for (i = 0; i < n && ok; i++) begin
      if (m[i][i] == 0) begin
        hit = -1;
        for (j = i + 1; j < n && hit < 0; j++) if (m[j][i] != 0) hit = j;
        if (hit < 0) ok = 1'b0;
        else for (k = 0; k < w; k++) begin
          t = m[i][k]; m[i][k] = m[hit][k]; m[hit][k] = t;
        end
      end
      if (ok) begin
        for (j = i + 1; j < n; j++) begin
          ratio = fx_div(m[j][i], m[i][i]);
          for (k = i; k < w; k++) m[j][k] = fx_sub(m[j][k], fx_mul(ratio, m[i][k]));
        end
      end
    end
    foreach (matrix_q[c]) matrix_q[c] = '0;
    loaded_cnt = 0;
    if (!ok) begin
      pending_q.push_back('{value: '0, index: '0, sing: 1'b1, last: 1'b1});
      return;
    end
    for (i = n - 1; i >= 0; i--) begin
      acc = m[i][n];
      for (j = i + 1; j < n; j++) acc = fx_sub(acc, fx_mul(m[i][j], unknowns_q[j]));
      unknowns_q[i] = fx_div(acc, m[i][i]);
      pending_q.push_back('{value: unknowns_q[i], index: IdxOutW'(i), sing: 1'b0,
                            last: i == 0});
    end
  endtask

  // predict on accepted items, check accepted results, watch for a hang
  always @(posedge clk_i) begin
    solution_t exp_s;
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && in_ready_o) begin
        load_and_solve(entry_value_i, last_entry_i);
        idle_cycles = 0;
      end
      if (out_valid_o && out_ready_i) begin
        idle_cycles = 0;
        results_seen++;
        if (pending_q.size() == 0) begin
          $error("unexpected result value=%0d index=%0d", solution_value_o, unknown_index_o);
          error_cnt++;
        end else begin
          exp_s = pending_q.pop_front();
          if (singular_o) singular_seen++;
          if (solution_value_o !== exp_s.value) begin
            $error("solution_value exp %0d got %0d", exp_s.value, solution_value_o);
            error_cnt++;
          end
          if (unknown_index_o !== exp_s.index) begin
            $error("unknown_index exp %0d got %0d", exp_s.index, unknown_index_o);
            error_cnt++;
          end
          if (singular_o !== exp_s.sing) begin
            $error("singular exp %0d got %0d", exp_s.sing, singular_o);
            error_cnt++;
          end
          if (last_result_o !== exp_s.last) begin
            $error("last_result exp %0d got %0d", exp_s.last, last_result_o);
            error_cnt++;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // receiver: long hold when asked, otherwise a shifting stall pattern
  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      case ((results_seen / 16) % 3)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // offer one item and hold it until accepted, with bursts and gaps
  task automatic send_entry(input logic signed [EntryW-1:0] v, input logic lst);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    entry_value_i <= v;
    last_entry_i <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // drop valid, then wait until every result is in and the block is idle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0 || !in_ready_o) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_size(input int unsigned sz);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= SizeW'(sz);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = sz;
  endtask

  function automatic logic signed [EntryW-1:0] pick_entry();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return 16'sh8000;
      3: return 16'sh7fff;
      4, 5, 6: return EntryW'($signed($urandom_range(0, 16)) - 8);
      default: return EntryW'($urandom);
    endcase
  endfunction

  // shape: 0 regular, 1 zero pivot, 2 singular column, 3 short, 4 excess
  task automatic send_system(input int shape);
    logic signed [EntryW-1:0] vals[$];
    int n, w, cnt, r, c;
    n = (size_reg == 0) ? 1 : size_reg;
    w = n + 1;
    for (r = 0; r < n; r++)
      for (c = 0; c < w; c++) vals.push_back(pick_entry());
    if (shape == 1) vals[0] = '0;
    if (shape == 2) for (r = 0; r < n; r++) vals[r*w] = '0;
    cnt = n * w;
    if (shape == 3) cnt = $urandom_range(1, n * w);
    if (shape == 4) begin
      cnt = n * w + $urandom_range(1, 4);
      while (vals.size() < cnt) vals.push_back(EntryW'($urandom));
    end
    for (c = 0; c < cnt; c++) send_entry(vals[c], c == cnt - 1);
    systems_sent++;
  endtask

  task automatic test_full_pivot_swap();
    logic signed [EntryW-1:0] v[12];
    int c;
    // zero pivot in row 0, swap with row 1; extremes of the entry field
    v = '{16'sd0, 16'sd2, 16'sd1, 16'sh7fff,
          16'sh8000, 16'sd1, 16'sd3, -16'sd5,
          16'sd4, 16'sh7fff, 16'sh8000, 16'sd1};
    for (c = 0; c < 12; c++) send_entry(v[c], c == 11);
    systems_sent++;
  endtask

  task automatic test_small_sizes();
    write_size(1);
    send_entry(16'sd0, 1'b0);
    send_entry(16'sd7, 1'b1);
    systems_sent++;
    write_size(0);
    send_entry(16'sh8000, 1'b0);
    send_entry(16'sh7fff, 1'b1);
    systems_sent++;
    // extra entries beyond the system are dropped
    send_entry(-16'sd3, 1'b0);
    send_entry(16'sd9, 1'b0);
    send_entry(16'sd1, 1'b0);
    send_entry(16'sd1, 1'b1);
    systems_sent++;
  endtask

  task automatic test_short_system();
    write_size(2);
    send_entry(16'sd3, 1'b0);
    send_entry(16'sd1, 1'b0);
    send_entry(16'sd6, 1'b1);
    systems_sent++;
  endtask

  task automatic test_backpressure();
    write_size(3);
    stall_hold = 3000;
    repeat (3) send_system(0);
    wait_drained();
    send_system(2);
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned start;
    start = items_sent;
    while (items_sent - start < 410) begin
      if ($urandom_range(0, 5) == 0) write_size($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_system(0);
        4, 5: send_system(1);
        6: send_system(2);
        7, 8: send_system(3);
        default: send_system(4);
      endcase
    end
  endtask

  initial begin
    int unsigned n_wait;
    foreach (matrix_q[c]) matrix_q[c] = '0;
    foreach (unknowns_q[c]) unknowns_q[c] = '0;
    loaded_cnt = 0;
    size_reg = SizeReset;
    stall_hold = 0;
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_pivot_swap();
    test_small_sizes();
    test_short_system();
    test_backpressure();
    test_random();
    wait_drained();
    n_wait = 0;
    while (pending_q.size() != 0 && n_wait < 5000) begin
      @(posedge clk_i);
      n_wait++;
    end
    repeat (100) @(posedge clk_i);
    $display("tb: %0d entries in %0d systems, %0d results (%0d singular), sizes 0..3",
             items_sent, systems_sent, results_seen, singular_seen);
    if (error_cnt == 0 && pending_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
